FILE: hw/rtl/nst_pkg.sv
// ---------------------------------------------------------------------------
// nst_pkg: shared definitions for the named slot table
// Command and status codes, result layout and key normalization.
// ---------------------------------------------------------------------------
package nst_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int NAME_BYTES_DEF = 12;
  localparam int KEY_BYTES      = 12;
  localparam int STORE_BYTES    = 11;
  localparam int STORE_BITS     = STORE_BYTES * 8;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_NAME  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [STORE_BITS-1:0] name;
    logic                  bad;
  } key_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [3:0]          slot_number;
    logic [63:0]         found_low;
    logic [23:0]         found_high;
  } result_t;

  // Zero every byte after the first zero byte and every byte at or above nb.
  // A key is bad when empty or when no terminator falls inside the first nb
  // bytes.
  function automatic key_t key_normalize(logic [63:0] lo, logic [31:0] hi, int nb);
    logic [KEY_BYTES*8-1:0] raw;
    logic [7:0]             b;
    logic                   ended;
    logic                   zero_in_range;
    key_t                   k;
    raw           = {hi, lo};
    ended         = 1'b0;
    zero_in_range = 1'b0;
    k.name        = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[8*i +: 8];
      if (i >= nb) begin
        b = 8'h00;
      end
      if (b == 8'h00) begin
        ended = 1'b1;
        if (i < nb) begin
          zero_in_range = 1'b1;
        end
      end
      if (!ended && i < STORE_BYTES) begin
        k.name[8*i +: 8] = b;
      end
    end
    k.bad = (raw[7:0] == 8'h00) || !zero_in_range;
    return k;
  endfunction

endpackage

FILE: hw/rtl/nst_if.sv
// ---------------------------------------------------------------------------
// nst_if: request and response channels of the named slot table
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface nst_cmd_if import nst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [63:0]      key_low;
  logic [31:0]      key_high;
  logic [7:0]       slot_query;

  modport source (output valid, cmd, key_low, key_high, slot_query, input ready);
  modport sink   (input valid, cmd, key_low, key_high, slot_query, output ready);
endinterface

interface nst_rsp_if import nst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [3:0]          slot_number;
  logic [63:0]         found_low;
  logic [23:0]         found_high;

  modport source (output valid, status, slot_number, found_low, found_high, input ready);
  modport sink   (input valid, status, slot_number, found_low, found_high, output ready);
endinterface

FILE: hw/rtl/named_slot_table.sv
// ---------------------------------------------------------------------------
// named_slot_table: table of named slots with find, create, delete and read
// Top level: command sequencer, slot store and response register.
// ---------------------------------------------------------------------------
// Usage:
//   A request transaction carries cmd, a name key of up to twelve bytes
//   (key_low, key_high, byte 0 in the low bits) and slot_query for reads.
//   A response transaction carries status, slot_number and, for a read
//   that hits an occupied slot, the stored name in found_low/found_high.
//   Exactly one response follows each request, in order.
// Operation:
//   Find, create and delete scan the slots one per cycle through the single
//   store read port and one shared comparator, and stop early on a match.
//   A bad key is answered without a scan, a read with one store access.
//   One command is in flight at a time; request ready drops from the
//   accepting cycle until the result is handed over.
// Reset:
//   All slot occupied flags clear at once; the table is empty and the block
//   is ready in the first cycle after reset. No clearing sweep is needed.
// Stall:
//   A finished result waits in the response register while the receiver
//   holds ready low; the sequencer takes one more request and holds its
//   result until the register frees.
// ---------------------------------------------------------------------------
module named_slot_table import nst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nst_cmd_if.sink   request,
  nst_rsp_if.source response
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  logic                  res_valid;
  logic                  res_take;
  result_t               res;
  logic [SLOT_W-1:0]     rd_addr;
  logic [STORE_BITS-1:0] rd_data;
  logic                  rd_occ;
  logic                  wr_en;
  logic                  clr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [STORE_BITS-1:0] wr_data;

  logic                  out_valid;
  result_t               out_q;

  nst_scan_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .NAME_BYTES (NAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rd_occ    (rd_occ),
    .wr_en     (wr_en),
    .clr_en    (clr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  nst_slot_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_occ  (rd_occ),
    .wr_en   (wr_en),
    .clr_en  (clr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Load the response register whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid || response.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign response.valid       = out_valid;
  assign response.status      = out_q.status;
  assign response.slot_number = out_q.slot_number;
  assign response.found_low   = out_q.found_low;
  assign response.found_high  = out_q.found_high;

  // One command at a time: ready drops right after a request transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("request accepted while a command is in flight");

  // Store writes and clears happen only while a command is being resolved.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en || clr_en) |-> (!request.ready && !res_valid))
    else $error("slot store modified outside a command");

  // A response never stands valid in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !response.valid)
    else $error("response valid right after reset");

endmodule

FILE: hw/rtl/nst_slot_store.sv
// ---------------------------------------------------------------------------
// nst_slot_store: slot name memory with per-slot occupied flags
// One registered read port, one write port; flags clear at reset.
// ---------------------------------------------------------------------------
module nst_slot_store import nst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic [STORE_BITS-1:0]         rd_data,
  output logic                          rd_occ,
  input  logic                          wr_en,
  input  logic                          clr_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  logic [STORE_BITS-1:0]         wr_data
);

  logic [STORE_BITS-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occ;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_occ <= 1'b0;
    end else begin
      rd_occ <= occ[rd_addr];
      if (wr_en) begin
        occ[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        occ[wr_addr] <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/nst_scan_ctrl.sv
// ---------------------------------------------------------------------------
// nst_scan_ctrl: command sequencer and shared name comparator
// Scans slots one per cycle through the store read port and builds a result.
// ---------------------------------------------------------------------------
module nst_scan_ctrl import nst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  nst_cmd_if.sink                       request,
  output logic                          res_valid,
  input  logic                          res_take,
  output result_t                       res,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  input  logic [STORE_BITS-1:0]         rd_data,
  input  logic                          rd_occ,
  output logic                          wr_en,
  output logic                          clr_en,
  output logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  output logic [STORE_BITS-1:0]         wr_data
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = SLOT_W + 1;
  localparam logic [CNT_W-1:0]  SLOT_END  = CNT_W'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_RDADDR = 3'd2;
  localparam logic [2:0] S_RDDATA = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state, state_next;
  logic [CMD_W-1:0]  cmd_q;
  logic [STORE_BITS-1:0] key_q;
  logic [SLOT_W-1:0] q_idx;
  logic              q_ok;
  logic [CNT_W-1:0]  iss;
  logic              cmp_vld;
  logic [SLOT_W-1:0] cmp_idx;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  result_t           res_q, res_next;
  logic              res_load;

  key_t              key_in;
  logic              accept;
  logic              iss_live;
  logic              hit;
  logic              last;
  logic              free_here;
  logic              have_free;
  logic [SLOT_W-1:0] free_sel;

  assign key_in   = key_normalize(request.key_low, request.key_high, NAME_BYTES);
  assign request.ready = (state == S_IDLE);
  assign accept   = request.valid && request.ready;
  assign iss_live = (iss < SLOT_END);

  // One comparator serves every slot in turn.
  assign hit       = cmp_vld && rd_occ && (rd_data == key_q);
  assign last      = cmp_vld && (cmp_idx == SLOT_LAST);
  assign free_here = cmp_vld && !rd_occ;
  assign have_free = free_found || free_here;
  assign free_sel  = free_found ? free_idx : cmp_idx;

  assign wr_data   = key_q;
  assign res       = res_q;
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    res_next   = '0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    wr_addr    = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && request.cmd == CMD_READ) begin
          state_next = S_RDADDR;
        end else if (accept && key_in.bad) begin
          res_load        = 1'b1;
          res_next.status = (request.cmd == CMD_CREATE) ? ST_BAD_NAME : ST_NOT_FOUND;
          state_next      = S_DONE;
        end else if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_live) begin
          rd_addr = iss[SLOT_W-1:0];
        end
        if (hit) begin
          res_load             = 1'b1;
          res_next.status      = ST_FOUND;
          res_next.slot_number = 4'(cmp_idx);
          clr_en               = (cmd_q == CMD_DELETE);
          wr_addr              = cmp_idx;
          state_next           = S_DONE;
        end else if (last) begin
          res_load   = 1'b1;
          state_next = S_DONE;
          if (cmd_q == CMD_CREATE && have_free) begin
            wr_en                = 1'b1;
            wr_addr              = free_sel;
            res_next.status      = ST_CREATED;
            res_next.slot_number = 4'(free_sel);
          end else if (cmd_q == CMD_CREATE) begin
            res_next.status = ST_FULL;
          end else begin
            res_next.status = ST_NOT_FOUND;
          end
        end
      end
      S_RDADDR: begin
        rd_addr    = q_idx;
        state_next = S_RDDATA;
      end
      S_RDDATA: begin
        res_load   = 1'b1;
        state_next = S_DONE;
        if (q_ok && rd_occ) begin
          res_next.status      = ST_FOUND;
          res_next.slot_number = 4'(q_idx);
          res_next.found_low   = rd_data[63:0];
          res_next.found_high  = rd_data[STORE_BITS-1:64];
        end else begin
          res_next.status = ST_EMPTY;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      iss        <= '0;
    end else if (state == S_IDLE) begin
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      iss        <= '0;
    end else if (state == S_SCAN) begin
      cmp_vld <= iss_live;
      if (iss_live) begin
        iss <= iss + CNT_W'(1);
      end
      if (free_here && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= request.cmd;
      key_q <= key_in.name;
      q_ok  <= ({1'b0, request.slot_query} < 9'(SLOT_COUNT));
      q_idx <= SLOT_W'(request.slot_query);
    end
    if (state == S_SCAN) begin
      cmp_idx <= iss[SLOT_W-1:0];
      if (free_here && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
    if (res_load) begin
      res_q <= res_next;
    end
  end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the named slot table
// Drives find, create, delete and read requests through the valid/ready
// request channel, predicts every response from a local copy of the slot
// names or takes it typed in from a directed row, and compares each response
// field by field, in order. A short table of directed requests comes first,
// then a long random mix of well-formed name traffic, odd-length keys and
// raw noise, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
  import nst_pkg::*;

  localparam int     SLOTS        = SLOT_COUNT_DEF;
  localparam int     POOL         = 40;
  localparam int     RANDOM_ITEMS = 1825;
  localparam int     MAX_IDLE     = 18;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     REPORT_MAX   = 10;
  localparam longint CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [63:0]      key_low;
    logic [31:0]      key_high;
    logic [7:0]       slot_query;
  } request_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Free-running clock, period 10.
  always #5 clk = ~clk;

  nst_cmd_if request_ch ();
  nst_rsp_if response_ch ();

  named_slot_table dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  // Local copy of the slot names: 11 bytes each, zero padded, byte 0 low.
  // A slot is occupied when byte 0 is nonzero.
  logic [87:0] stored_name [SLOTS];
  // Candidate names for well-formed traffic.
  logic [87:0] name_pool [POOL];
  // Responses still owed by the block, oldest first.
  result_t     owed_responses [$];

  // Typed expectation for the directed row currently on the request channel.
  bit          row_typed = 1'b0;
  result_t     row_want  = '0;

  longint      cycle_count    = 0;
  int          requests_taken = 0;
  int          responses_seen = 0;
  int          failures       = 0;
  int          status_seen [8];

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Cut the key at its first zero byte and return the name length, capped at
  // the full key width when no zero byte is present.
  function automatic int normalize_name(input logic [63:0] lo, input logic [31:0] hi,
                                        output logic [87:0] name);
    logic [95:0] raw;
    logic [7:0]  b;
    bit          ended;
    int          len;
    raw   = {hi, lo};
    name  = '0;
    ended = 1'b0;
    len   = KEY_BYTES;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[8*i +: 8];
      if (!ended && b == 8'h00) begin
        ended = 1'b1;
        len   = i;
      end
      if (!ended && i < STORE_BYTES) begin
        name[8*i +: 8] = b;
      end
    end
    return len;
  endfunction

  // Work out the response to one request and apply its effect on the slots.
  function automatic result_t predict_slot_table(input request_t rq);
    logic [87:0] name;
    int          len;
    int          hit;
    result_t     r;
    logic [3:0]  q;
    r        = '0;
    r.status = ST_NOT_FOUND;
    len      = normalize_name(rq.key_low, rq.key_high, name);
    hit      = -1;
    // Only a name of legal length can ever match a stored one.
    if (len >= 1 && len < NAME_BYTES_DEF) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && stored_name[i][7:0] != 8'h00 && stored_name[i] == name) begin
          hit = i;
        end
      end
    end
    case (rq.cmd)
      CMD_FIND: begin
        if (hit >= 0) begin
          r.status      = ST_FOUND;
          r.slot_number = 4'(hit);
        end
      end
      CMD_CREATE: begin
        if (len == 0 || len >= NAME_BYTES_DEF) begin
          r.status = ST_BAD_NAME;
        end else if (hit >= 0) begin
          r.status      = ST_FOUND;
          r.slot_number = 4'(hit);
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (r.status == ST_FULL && stored_name[i][7:0] == 8'h00) begin
              stored_name[i] = name;
              r.status       = ST_CREATED;
              r.slot_number  = 4'(i);
            end
          end
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          stored_name[hit] = '0;
          r.status         = ST_FOUND;
          r.slot_number    = 4'(hit);
        end
      end
      default: begin
        q        = rq.slot_query[3:0];
        r.status = ST_EMPTY;
        if (rq.slot_query < SLOTS && stored_name[q][7:0] != 8'h00) begin
          r.status      = ST_FOUND;
          r.slot_number = q;
          r.found_low   = stored_name[q][63:0];
          r.found_high  = stored_name[q][87:64];
        end
      end
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Build a key for a stored-form name: terminate it with a zero byte and
  // fill the ignored tail with either zeros or garbage.
  function automatic logic [95:0] key_for(input logic [87:0] name);
    logic [95:0] raw;
    bit          ended;
    bit          zero_tail;
    raw       = {$urandom, $urandom, $urandom};
    zero_tail = $urandom_range(0, 1);
    ended     = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (!ended && (i == STORE_BYTES || name[8*i +: 8] == 8'h00)) begin
        ended          = 1'b1;
        raw[8*i +: 8]  = 8'h00;
      end else if (!ended) begin
        raw[8*i +: 8]  = name[8*i +: 8];
      end else if (zero_tail) begin
        raw[8*i +: 8]  = 8'h00;
      end
    end
    return raw;
  endfunction

  // Either an empty key with garbage behind it, or a full twelve-byte key
  // with no terminator.
  function automatic logic [95:0] odd_length_key();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      raw[7:0] = 8'h00;
    end else begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        raw[8*i +: 8] = 8'($urandom_range(1, 255));
      end
    end
    return raw;
  endfunction

  // One random request. Phases alternate between filling and draining the
  // table; finds and deletes mostly aim at names that are stored right now.
  function automatic request_t random_request(input int n);
    request_t         rq;
    int               roll;
    bit               draining;
    int               occupied [$];
    logic [87:0]      target;
    logic [CMD_W-1:0] name_cmds [3];
    name_cmds     = '{CMD_FIND, CMD_CREATE, CMD_DELETE};
    draining      = ((n / 300) % 2) == 1;
    roll          = $urandom_range(0, 99);
    rq.slot_query = 8'($urandom_range(0, SLOTS - 1));
    for (int i = 0; i < SLOTS; i++) begin
      if (stored_name[i][7:0] != 8'h00) begin
        occupied.push_back(i);
      end
    end
    target = name_pool[$urandom_range(0, POOL - 1)];
    if (roll < 52) begin
      // Create or delete, weighted by the phase.
      if ((roll < 40) != draining) begin
        rq.cmd = CMD_CREATE;
      end else begin
        rq.cmd = CMD_DELETE;
      end
    end else if (roll < 70) begin
      rq.cmd = CMD_FIND;
    end else if (roll < 85) begin
      rq.cmd = CMD_READ;
      if ($urandom_range(0, 7) == 0) begin
        rq.slot_query = 8'($urandom_range(SLOTS, 255));
      end
    end else begin
      rq.cmd = name_cmds[$urandom_range(0, 2)];
    end
    if ((rq.cmd == CMD_FIND || rq.cmd == CMD_DELETE) && occupied.size() != 0 &&
        $urandom_range(0, 3) != 0) begin
      target = stored_name[occupied[$urandom_range(0, occupied.size() - 1)]];
    end
    {rq.key_high, rq.key_low} = key_for(target);
    if (roll >= 85 && roll < 90) begin
      {rq.key_high, rq.key_low} = odd_length_key();
    end else if (roll >= 90) begin
      // Raw noise on every field.
      rq.cmd        = CMD_W'($urandom);
      rq.key_low    = {$urandom, $urandom};
      rq.key_high   = $urandom;
      rq.slot_query = 8'($urandom);
    end
    return rq;
  endfunction

  // Present one request and hold it until the block takes it. Called at a
  // falling edge, returns at the falling edge after the transaction.
  task automatic send_request(input request_t rq, input bit typed, input result_t want,
                              input int gap);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_ch.cmd        <= rq.cmd;
    request_ch.key_low    <= rq.key_low;
    request_ch.key_high   <= rq.key_high;
    request_ch.slot_query <= rq.slot_query;
    request_ch.valid      <= 1'b1;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed response has come back.
  task automatic wait_until_settled();
    request_ch.valid <= 1'b0;
    do @(negedge clk); while (owed_responses.size() != 0);
  endtask

  // -------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      cycle_count++;
      // Predict at the moment the request transaction moves.
      if (request_ch.valid === 1'b1 && request_ch.ready === 1'b1) begin
        want = predict_slot_table('{request_ch.cmd, request_ch.key_low,
                                    request_ch.key_high, request_ch.slot_query});
        if (row_typed) begin
          want = row_want;
        end
        owed_responses.push_back(want);
        requests_taken++;
      end
      // Compare each response transaction with the oldest owed one.
      if (response_ch.valid === 1'b1 && response_ch.ready === 1'b1) begin
        got.status      = response_ch.status;
        got.slot_number = response_ch.slot_number;
        got.found_low   = response_ch.found_low;
        got.found_high  = response_ch.found_high;
        responses_seen++;
        status_seen[got.status]++;
        if (owed_responses.size() == 0) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("cycle %0d: response with none owed: status %0d slot %0d",
                     cycle_count, got.status, got.slot_number);
          end
        end else begin
          want = owed_responses.pop_front();
          if (got.status !== want.status || got.slot_number !== want.slot_number ||
              got.found_low !== want.found_low || got.found_high !== want.found_high) begin
            failures++;
            if (failures <= REPORT_MAX) begin
              $display("cycle %0d: response %0d mismatch", cycle_count, responses_seen);
              $display("  got  status %0d slot %0d name %h_%h", got.status,
                       got.slot_number, got.found_high, got.found_low);
              $display("  want status %0d slot %0d name %h_%h", want.status,
                       want.slot_number, want.found_high, want.found_low);
            end
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("cycle limit reached with %0d responses owed", owed_responses.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Response side: drop ready for a random number of cycles per transaction,
  // with stretches where ready stays high.
  // -------------------------------------------------------------------------
  initial begin : response_sink
    int wait_cycles;
    int taken;
    taken             = 0;
    response_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      wait_cycles = (((taken / 89) % 3) == 1) ? 0 : $urandom_range(0, MAX_IDLE);
      if (wait_cycles > 0) begin
        response_ch.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      response_ch.ready <= 1'b1;
      do @(posedge clk); while (!(response_ch.valid === 1'b1 && !rst));
      taken++;
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Request side: directed table, then random traffic, then drain
  // -------------------------------------------------------------------------
  initial begin : request_source
    table_row_t rows [$];
    table_row_t row;
    request_t   rq;
    int         len;
    int         gap;
    int         directed_count;

    // Hold every input at a known value through reset.
    request_ch.valid      <= 1'b0;
    request_ch.cmd        <= CMD_FIND;
    request_ch.key_low    <= '0;
    request_ch.key_high   <= '0;
    request_ch.slot_query <= '0;
    foreach (stored_name[i]) stored_name[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Name pool: make sure the shortest and longest legal names show up.
    for (int i = 0; i < POOL; i++) begin
      len = (i % 8 == 0) ? STORE_BYTES : (i % 8 == 1) ? 1 : $urandom_range(1, STORE_BYTES);
      name_pool[i] = '0;
      for (int j = 0; j < len; j++) begin
        name_pool[i][8*j +: 8] = 8'($urandom_range(1, 255));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows. Fields: cmd, key_low, key_high, slot_query, whether the
    // response is typed in here, then status, slot, found_low, found_high.
    // Untyped rows fall back on the predictor.
    rows = '{
      // Empty table after reset.
      '{'{CMD_READ,   64'h0, 32'h0, 8'd0},   1, '{ST_EMPTY, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_FIND,   64'h41, 32'h0, 8'd0},  1, '{ST_NOT_FOUND, 4'd0, 64'h0, 24'h0}},
      // Empty name with garbage behind it, and a name with no terminator.
      '{'{CMD_CREATE, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 8'd0},
        1, '{ST_BAD_NAME, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_CREATE, {8{8'h61}}, 32'h6161_6161, 8'd0},
        1, '{ST_BAD_NAME, 4'd0, 64'h0, 24'h0}},
      // Shortest and longest legal names.
      '{'{CMD_CREATE, 64'h41, 32'h0, 8'd0},  1, '{ST_CREATED, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_READ,   64'h0, 32'h0, 8'd0},   1, '{ST_FOUND, 4'd0, 64'h41, 24'h0}},
      '{'{CMD_CREATE, {64{1'b1}}, 32'h00FF_FFFF, 8'd0},
        1, '{ST_CREATED, 4'd1, 64'h0, 24'h0}},
      '{'{CMD_READ,   64'h0, 32'h0, 8'd1},
        1, '{ST_FOUND, 4'd1, {64{1'b1}}, 24'hFF_FFFF}},
      // Existing name again, garbage after the terminator is ignored.
      '{'{CMD_CREATE, 64'hDEAD_BEEF_1234_0041, 32'hFFFF_FFFF, 8'd0},
        1, '{ST_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_FIND,   {64{1'b1}}, 32'h00FF_FFFF, 8'd0},
        1, '{ST_FOUND, 4'd1, 64'h0, 24'h0}},
      // Read indexes out of range and of an empty slot.
      '{'{CMD_READ,   64'h0, 32'h0, 8'd255}, 1, '{ST_EMPTY, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_READ,   64'h0, 32'h0, 8'd16},  1, '{ST_EMPTY, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_READ,   64'h0, 32'h0, 8'd15},  1, '{ST_EMPTY, 4'd0, 64'h0, 24'h0}},
      // Empty and over-long keys can never match on find or delete.
      '{'{CMD_FIND,   64'h4100, 32'h0, 8'd0},
        1, '{ST_NOT_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_FIND,   {8{8'h61}}, 32'h6161_6161, 8'd0},
        1, '{ST_NOT_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_DELETE, {8{8'h61}}, 32'h6161_6161, 8'd0},
        1, '{ST_NOT_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_DELETE, 64'h0, 32'h0, 8'd0},   1, '{ST_NOT_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_CREATE, 64'h4241, 32'h0, 8'd0}, 1, '{ST_CREATED, 4'd2, 64'h0, 24'h0}},
      // Delete frees the slot, a second delete misses, create reuses it.
      '{'{CMD_DELETE, 64'h41, 32'h0, 8'd0},  1, '{ST_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_READ,   64'h0, 32'h0, 8'd0},   1, '{ST_EMPTY, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_DELETE, 64'h41, 32'h0, 8'd0},  1, '{ST_NOT_FOUND, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_CREATE, 64'h42, 32'h0, 8'd0},  1, '{ST_CREATED, 4'd0, 64'h0, 24'h0}},
      '{'{CMD_FIND,   64'h4241, 32'h0, 8'd0}, 1, '{ST_FOUND, 4'd2, 64'h0, 24'h0}},
      '{'{CMD_READ,   64'hFFFF, 32'h1, 8'd2}, 0, '0},
      '{'{CMD_DELETE, {64{1'b1}}, 32'h00FF_FFFF, 8'd0},
        1, '{ST_FOUND, 4'd1, 64'h0, 24'h0}}
    };
    directed_count = rows.size();

    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.req, row.typed, row.want, $urandom_range(0, MAX_IDLE));
    end
    wait_until_settled();

    // Random traffic; settle once more halfway through.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        wait_until_settled();
      end
      rq  = random_request(n);
      gap = (((n / 97) % 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      send_request(rq, 1'b0, '0, gap);
    end

    // Drain: every owed response, then a quiet stretch for stray ones.
    wait_until_settled();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d requests (%0d directed) and checked %0d responses in %0d cycles.",
             requests_taken, directed_count, responses_seen, cycle_count);
    $display("Statuses: found %0d, created %0d, not found %0d, bad name %0d, full %0d, empty %0d.",
             status_seen[ST_FOUND], status_seen[ST_CREATED], status_seen[ST_NOT_FOUND],
             status_seen[ST_BAD_NAME], status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", failures);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/nst_pkg.sv
hw/rtl/nst_if.sv
hw/rtl/nst_slot_store.sv
hw/rtl/nst_scan_ctrl.sv
hw/rtl/named_slot_table.sv
tb/tb_top.sv
